// ===== design/gyhi_pkg.sv =====
package gyhi_pkg;

  // Field widths of the sample and result beats.
  localparam int MODE_W  = 2;
  localparam int RAW_W   = 16;
  localparam int EL_W    = 24;
  localparam int HEAD_W  = 25;
  localparam int BIAS_W  = 24;
  localparam int DRIFT_W = 25;
  localparam int GAIN_W  = 32;
  localparam int TIMER_W = 32;
  localparam int MUL_W   = 32;

  // Heading format: degrees with a fixed number of fraction bits.
  localparam int HEADING_FRAC_BITS = 16;
  localparam logic [HEAD_W-1:0] FULL_CIRCLE = HEAD_W'(360) << HEADING_FRAC_BITS;
  localparam logic [HEAD_W-1:0] HALF_CIRCLE = FULL_CIRCLE >> 1;

  // Rate scaling: |d| * elapsed * gain / 2^40.
  localparam int D_W      = 25;
  localparam int M_W      = D_W + EL_W;
  localparam int M_LO_W   = 24;
  localparam int M_HI_W   = M_W - M_LO_W;
  localparam int LO_P_W   = M_LO_W + GAIN_W;
  localparam int LOQ_W    = LO_P_W + 1 - M_LO_W;
  localparam int HI_P_W   = M_HI_W + GAIN_W;
  localparam int MAG_W    = 40;
  localparam int X_W      = MAG_W - HEADING_FRAC_BITS;
  localparam int DEG_W    = 9;
  localparam logic [LO_P_W:0] ROUND_Q40 = (LO_P_W + 1)'(64'd1 << 39);

  // Integer degrees modulo 360 by a reciprocal multiply.
  localparam int RECIP_SHIFT = 32;
  localparam int Q_W         = X_W - 8;
  localparam logic [X_W-1:0] RECIP_360 = X_W'((64'd1 << RECIP_SHIFT) / 360);
  localparam logic [X_W:0]   DEG_360   = (X_W + 1)'(360);

  // Register reset values.
  localparam logic [GAIN_W-1:0]  RATE_GAIN_RST    = 32'd4294967;
  localparam logic [TIMER_W-1:0] DRIFT_PERIOD_RST = 32'd1000000;

  // Configuration register indexes.
  localparam logic CFG_RATE_GAIN    = 1'b0;
  localparam logic CFG_DRIFT_PERIOD = 1'b1;

  // Sample modes.
  localparam logic [MODE_W-1:0] MODE_INT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CAL   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DRIFT = 2'd2;

  // Operand selection of the shared multiplier.
  typedef enum logic [1:0] {
    MUL_D_EL,
    MUL_LO_GAIN,
    MUL_HI_GAIN,
    MUL_X_RECIP
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAL,
    ST_MUL_D,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_MUL_Q,
    ST_REM,
    ST_HEAD,
    ST_CORR,
    ST_WIN,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     capture;
    mul_sel_t mul_sel;
    logic     cal_step;
    logic     m_load;
    logic     lo_load;
    logic     x_load;
    logic     rem_load;
    logic     head_step;
    logic     corr_step;
    logic     win_step;
    logic     out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              out_free;
  } status_t;

endpackage

// ===== design/gyhi_if.sv =====
interface gyhi_in_if;
  logic                             valid;
  logic                             ready;
  logic [gyhi_pkg::MODE_W-1:0]      mode;
  logic signed [gyhi_pkg::RAW_W-1:0] raw_rate;
  logic [gyhi_pkg::EL_W-1:0]        elapsed_us;

  modport source (output valid, output mode, output raw_rate, output elapsed_us, input ready);
  modport sink (input valid, input mode, input raw_rate, input elapsed_us, output ready);
endinterface

interface gyhi_out_if;
  logic                                valid;
  logic                                ready;
  logic [gyhi_pkg::HEAD_W-1:0]         heading_out;
  logic signed [gyhi_pkg::BIAS_W-1:0]  bias_out;
  logic signed [gyhi_pkg::DRIFT_W-1:0] drift_out;
  logic                                bias_ready;
  logic                                drift_ready;

  modport source (output valid, output heading_out, output bias_out, output drift_out,
                  output bias_ready, output drift_ready, input ready);
  modport sink (input valid, input heading_out, input bias_out, input drift_out,
                input bias_ready, input drift_ready, output ready);
endinterface

// ===== design/gyhi_mult.sv =====
module gyhi_mult (
  input  logic                          clk,
  input  logic [gyhi_pkg::MUL_W-1:0]    a,
  input  logic [gyhi_pkg::MUL_W-1:0]    b,
  output logic [2*gyhi_pkg::MUL_W-1:0]  prod_r
);

  // Unsigned product, registered every cycle.
  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

// ===== design/gyhi_ctrl.sv =====
module gyhi_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [gyhi_pkg::MODE_W-1:0] in_mode,
  output logic                        in_ready,
  input  gyhi_pkg::status_t           status,
  output gyhi_pkg::cmd_t              cmd
);

  gyhi_pkg::state_t state_r;
  gyhi_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gyhi_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gyhi_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (in_mode) inside
            gyhi_pkg::MODE_INT, gyhi_pkg::MODE_DRIFT: state_nxt = gyhi_pkg::ST_MUL_D;
            gyhi_pkg::MODE_CAL:                       state_nxt = gyhi_pkg::ST_CAL;
            default:                                  state_nxt = gyhi_pkg::ST_OUT;
          endcase
        end
      end
      gyhi_pkg::ST_CAL:    state_nxt = gyhi_pkg::ST_OUT;
      gyhi_pkg::ST_MUL_D:  state_nxt = gyhi_pkg::ST_MUL_LO;
      gyhi_pkg::ST_MUL_LO: state_nxt = gyhi_pkg::ST_MUL_HI;
      gyhi_pkg::ST_MUL_HI: state_nxt = gyhi_pkg::ST_SUM;
      gyhi_pkg::ST_SUM:    state_nxt = gyhi_pkg::ST_MUL_Q;
      gyhi_pkg::ST_MUL_Q:  state_nxt = gyhi_pkg::ST_REM;
      gyhi_pkg::ST_REM:    state_nxt = gyhi_pkg::ST_HEAD;
      gyhi_pkg::ST_HEAD:   state_nxt = gyhi_pkg::ST_CORR;
      gyhi_pkg::ST_CORR: begin
        if (status.mode == gyhi_pkg::MODE_DRIFT) begin
          state_nxt = gyhi_pkg::ST_WIN;
        end else begin
          state_nxt = gyhi_pkg::ST_OUT;
        end
      end
      gyhi_pkg::ST_WIN:    state_nxt = gyhi_pkg::ST_OUT;
      gyhi_pkg::ST_OUT: begin
        if (status.out_free) begin
          state_nxt = gyhi_pkg::ST_IDLE;
        end
      end
      default:             state_nxt = gyhi_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    cmd.mul_sel = gyhi_pkg::MUL_D_EL;
    unique case (state_r)
      gyhi_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      gyhi_pkg::ST_CAL:    cmd.cal_step = 1'b1;
      gyhi_pkg::ST_MUL_D:  cmd.mul_sel = gyhi_pkg::MUL_D_EL;
      gyhi_pkg::ST_MUL_LO: begin
        cmd.mul_sel = gyhi_pkg::MUL_LO_GAIN;
        cmd.m_load  = 1'b1;
      end
      gyhi_pkg::ST_MUL_HI: begin
        cmd.mul_sel = gyhi_pkg::MUL_HI_GAIN;
        cmd.lo_load = 1'b1;
      end
      gyhi_pkg::ST_SUM:    cmd.x_load = 1'b1;
      gyhi_pkg::ST_MUL_Q:  cmd.mul_sel = gyhi_pkg::MUL_X_RECIP;
      gyhi_pkg::ST_REM:    cmd.rem_load = 1'b1;
      gyhi_pkg::ST_HEAD:   cmd.head_step = 1'b1;
      gyhi_pkg::ST_CORR:   cmd.corr_step = 1'b1;
      gyhi_pkg::ST_WIN:    cmd.win_step = 1'b1;
      gyhi_pkg::ST_OUT:    cmd.out_load = status.out_free;
      default: begin
      end
    endcase
  end

endmodule

// ===== design/gyhi_dpath.sv =====
module gyhi_dpath #(
  parameter int CAL_COUNT = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  gyhi_pkg::cmd_t                     cmd,
  output gyhi_pkg::status_t                  status,
  input  logic                               cfg_we,
  input  logic                               cfg_idx,
  input  logic [gyhi_pkg::GAIN_W-1:0]        cfg_wdata,
  input  logic [gyhi_pkg::MODE_W-1:0]        in_mode,
  input  logic signed [gyhi_pkg::RAW_W-1:0]  in_raw_rate,
  input  logic [gyhi_pkg::EL_W-1:0]          in_elapsed_us,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [gyhi_pkg::HEAD_W-1:0]        out_heading,
  output logic signed [gyhi_pkg::BIAS_W-1:0] out_bias,
  output logic signed [gyhi_pkg::DRIFT_W-1:0] out_drift,
  output logic                               out_bias_ready,
  output logic                               out_drift_ready
);

  localparam int CAL_LOG2 = $clog2(CAL_COUNT);
  localparam int SUM_W    = gyhi_pkg::RAW_W + CAL_LOG2;
  localparam int CNT_W    = $clog2(CAL_COUNT + 1);
  localparam int SC_W     = SUM_W + 9;
  localparam logic [CNT_W-1:0] CAL_LAST = CNT_W'(CAL_COUNT);
  localparam logic [SC_W-1:0]  CAL_HALF = SC_W'(CAL_COUNT / 2);

  localparam int HW  = gyhi_pkg::HEAD_W;
  localparam int TW  = gyhi_pkg::TIMER_W;
  localparam int MW  = gyhi_pkg::MUL_W;

  // Configuration registers.
  logic [gyhi_pkg::GAIN_W-1:0] gain_r;
  logic [TW-1:0]               period_r;

  // Captured sample.
  logic [gyhi_pkg::MODE_W-1:0]       mode_r;
  logic signed [gyhi_pkg::RAW_W-1:0] raw_r;
  logic [gyhi_pkg::EL_W-1:0]         el_r;

  // Architectural state.
  logic [HW-1:0]                       head_r;
  logic signed [gyhi_pkg::BIAS_W-1:0]  bias_r;
  logic signed [gyhi_pkg::DRIFT_W-1:0] drift_r;
  logic signed [SUM_W-1:0]             sum_r;
  logic [CNT_W-1:0]                    cnt_r;
  logic [TW-1:0]                       ct_r;
  logic [TW-1:0]                       wt_r;
  logic [HW-1:0]                       wstart_r;
  logic                                bias_rdy_r;
  logic                                drift_rdy_r;
  logic                                active_r;

  // Datapath intermediates.
  logic [gyhi_pkg::M_W-1:0]               m_r;
  logic [gyhi_pkg::LOQ_W-1:0]             lo_r;
  logic [gyhi_pkg::X_W-1:0]               x_r;
  logic [gyhi_pkg::HEADING_FRAC_BITS-1:0] frac_r;
  logic [HW-1:0]                          rmag_r;
  logic                                   fire_r;

  // Result beat register.
  logic                                out_valid_r;
  logic [HW-1:0]                       out_heading_r;
  logic signed [gyhi_pkg::BIAS_W-1:0]  out_bias_r;
  logic signed [gyhi_pkg::DRIFT_W-1:0] out_drift_r;
  logic                                out_bias_ready_r;
  logic                                out_drift_ready_r;

  // Multiplier interface.
  logic [MW-1:0]   mul_a;
  logic [MW-1:0]   mul_b;
  logic [2*MW-1:0] prod_r;

  // Combinational helpers.
  logic signed [gyhi_pkg::D_W-1:0] d_val;
  logic                            d_neg;
  logic [gyhi_pkg::D_W-1:0]        d_abs;
  logic [gyhi_pkg::LO_P_W:0]       lo_round;
  logic [gyhi_pkg::HI_P_W:0]       scaled_sum;
  logic [gyhi_pkg::Q_W-1:0]        q_est;
  logic [gyhi_pkg::X_W:0]          deg_raw;
  logic [gyhi_pkg::DEG_W-1:0]      deg_rem;
  logic                            drift_neg;
  logic [HW-1:0]                   drift_mag;
  logic                            hadd_sub;
  logic [HW-1:0]                   hadd_mag;
  logic [HW-1:0]                   head_sum;
  logic [TW:0]                     ct_add;
  logic [TW-1:0]                   ct_sat;
  logic [TW:0]                     wt_add;
  logic [TW-1:0]                   wt_sat;
  logic [HW-1:0]                   win_diff;
  logic signed [gyhi_pkg::DRIFT_W-1:0] win_drift;
  logic signed [SUM_W-1:0]         sum_nxt;
  logic [CNT_W-1:0]                cnt_nxt;
  logic [SUM_W-1:0]                sum_mag;
  logic [SC_W-1:0]                 cal_scaled;
  logic [gyhi_pkg::BIAS_W-1:0]     cal_q;
  logic signed [gyhi_pkg::BIAS_W-1:0] cal_bias;

  // Heading update modulo the full circle; both operands are below it.
  function automatic logic [HW-1:0] circ_add(input logic [HW-1:0] h, input logic sub,
                                             input logic [HW-1:0] r);
    logic [HW:0] s;
    if (sub) begin
      s = {1'b0, h} - {1'b0, r};
      if (h < r) begin
        s = s + {1'b0, gyhi_pkg::FULL_CIRCLE};
      end
    end else begin
      s = {1'b0, h} + {1'b0, r};
      if (s >= {1'b0, gyhi_pkg::FULL_CIRCLE}) begin
        s = s - {1'b0, gyhi_pkg::FULL_CIRCLE};
      end
    end
    return s[HW-1:0];
  endfunction

  gyhi_mult u_mult (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  // Bias-corrected rate in Q8 and its magnitude.
  always_comb begin
    d_val = {{(gyhi_pkg::D_W - gyhi_pkg::RAW_W - 8){raw_r[gyhi_pkg::RAW_W-1]}}, raw_r, 8'd0}
            - {{(gyhi_pkg::D_W - gyhi_pkg::BIAS_W){bias_r[gyhi_pkg::BIAS_W-1]}}, bias_r};
    d_neg = d_val[gyhi_pkg::D_W-1];
    d_abs = d_neg ? gyhi_pkg::D_W'(-d_val) : gyhi_pkg::D_W'(d_val);
  end

  // Multiplier operand selection.
  always_comb begin
    case (cmd.mul_sel)
      gyhi_pkg::MUL_D_EL: begin
        mul_a = MW'(d_abs);
        mul_b = MW'(el_r);
      end
      gyhi_pkg::MUL_LO_GAIN: begin
        mul_a = MW'(prod_r[gyhi_pkg::M_LO_W-1:0]);
        mul_b = gain_r;
      end
      gyhi_pkg::MUL_HI_GAIN: begin
        mul_a = MW'(m_r[gyhi_pkg::M_W-1:gyhi_pkg::M_LO_W]);
        mul_b = gain_r;
      end
      default: begin
        mul_a = MW'(x_r);
        mul_b = MW'(gyhi_pkg::RECIP_360);
      end
    endcase
  end

  // Rounded scaling and the integer-degree remainder.
  always_comb begin
    lo_round   = {1'b0, prod_r[gyhi_pkg::LO_P_W-1:0]} + gyhi_pkg::ROUND_Q40;
    scaled_sum = prod_r[gyhi_pkg::HI_P_W:0] + (gyhi_pkg::HI_P_W + 1)'(lo_r);
    q_est      = prod_r[gyhi_pkg::RECIP_SHIFT + gyhi_pkg::Q_W - 1:gyhi_pkg::RECIP_SHIFT];
    deg_raw    = {1'b0, x_r} - ((gyhi_pkg::X_W + 1)'(q_est) * gyhi_pkg::DEG_360);
    if (deg_raw >= gyhi_pkg::DEG_360) begin
      deg_rem = gyhi_pkg::DEG_W'(deg_raw - gyhi_pkg::DEG_360);
    end else begin
      deg_rem = gyhi_pkg::DEG_W'(deg_raw);
    end
  end

  // Shared heading adder: the rate step or the drift correction.
  always_comb begin
    drift_neg = drift_r[gyhi_pkg::DRIFT_W-1];
    drift_mag = drift_neg ? HW'(-drift_r) : HW'(drift_r);
    if (cmd.corr_step) begin
      hadd_sub = !drift_neg;
      hadd_mag = drift_mag;
    end else begin
      hadd_sub = d_neg;
      hadd_mag = rmag_r;
    end
    head_sum = circ_add(head_r, hadd_sub, hadd_mag);
  end

  // Saturating timers and the drift window measurement.
  always_comb begin
    ct_add = {1'b0, ct_r} + (TW + 1)'(el_r);
    ct_sat = ct_add[TW] ? {TW{1'b1}} : ct_add[TW-1:0];
    wt_add = {1'b0, wt_r} + (TW + 1)'(el_r);
    wt_sat = wt_add[TW] ? {TW{1'b1}} : wt_add[TW-1:0];
    if (head_r >= wstart_r) begin
      win_diff = head_r - wstart_r;
    end else begin
      win_diff = head_r + gyhi_pkg::FULL_CIRCLE - wstart_r;
    end
    if (win_diff >= gyhi_pkg::HALF_CIRCLE) begin
      win_drift = $signed(win_diff - gyhi_pkg::FULL_CIRCLE);
    end else begin
      win_drift = $signed(win_diff);
    end
  end

  // Calibration sum and rounded average in Q8.
  always_comb begin
    sum_nxt    = sum_r + SUM_W'(raw_r);
    cnt_nxt    = cnt_r + CNT_W'(1);
    sum_mag    = sum_nxt[SUM_W-1] ? SUM_W'(-sum_nxt) : SUM_W'(sum_nxt);
    cal_scaled = ((SC_W'(sum_mag) << 8) + CAL_HALF) >> CAL_LOG2;
    cal_q      = gyhi_pkg::BIAS_W'(cal_scaled);
    cal_bias   = sum_nxt[SUM_W-1] ? $signed(-cal_q) : $signed(cal_q);
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= gyhi_pkg::RATE_GAIN_RST;
      period_r <= gyhi_pkg::DRIFT_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        gyhi_pkg::CFG_RATE_GAIN:    gain_r   <= cfg_wdata;
        gyhi_pkg::CFG_DRIFT_PERIOD: period_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Sample capture and arithmetic intermediates.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      raw_r  <= in_raw_rate;
      el_r   <= in_elapsed_us;
    end
    if (cmd.m_load) begin
      m_r <= prod_r[gyhi_pkg::M_W-1:0];
    end
    if (cmd.lo_load) begin
      lo_r <= lo_round[gyhi_pkg::LO_P_W:gyhi_pkg::M_LO_W];
    end
    if (cmd.x_load) begin
      x_r    <= scaled_sum[gyhi_pkg::MAG_W + 15:16 + gyhi_pkg::HEADING_FRAC_BITS];
      frac_r <= scaled_sum[15 + gyhi_pkg::HEADING_FRAC_BITS:16];
    end
    if (cmd.rem_load) begin
      rmag_r <= {deg_rem, frac_r};
    end
    if (cmd.head_step) begin
      fire_r <= ct_sat > period_r;
    end
  end

  // Heading, bias, drift, timers and flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      bias_r      <= '0;
      drift_r     <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      ct_r        <= '0;
      wt_r        <= '0;
      wstart_r    <= '0;
      bias_rdy_r  <= 1'b0;
      drift_rdy_r <= 1'b0;
      active_r    <= 1'b0;
    end else begin
      // Integrating and calibration samples abandon an open window.
      if (cmd.capture && (in_mode == gyhi_pkg::MODE_INT || in_mode == gyhi_pkg::MODE_CAL)) begin
        active_r <= 1'b0;
      end
      if (cmd.cal_step) begin
        if (cnt_nxt == CAL_LAST) begin
          bias_r     <= cal_bias;
          sum_r      <= '0;
          cnt_r      <= '0;
          bias_rdy_r <= 1'b1;
        end else begin
          sum_r <= sum_nxt;
          cnt_r <= cnt_nxt;
        end
      end
      if (cmd.head_step) begin
        head_r <= head_sum;
        ct_r   <= (ct_sat > period_r) ? '0 : ct_sat;
      end
      if (cmd.corr_step && fire_r) begin
        head_r <= head_sum;
      end
      if (cmd.win_step) begin
        if (!active_r) begin
          wstart_r <= head_r;
          wt_r     <= '0;
          active_r <= 1'b1;
        end else begin
          wt_r <= wt_sat;
          if (wt_sat >= period_r) begin
            drift_r     <= win_drift;
            drift_rdy_r <= 1'b1;
            active_r    <= 1'b0;
          end
        end
      end
    end
  end

  // Result beat handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result beat payload.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_heading_r     <= head_r;
      out_bias_r        <= bias_r;
      out_drift_r       <= drift_r;
      out_bias_ready_r  <= bias_rdy_r;
      out_drift_ready_r <= drift_rdy_r;
    end
  end

  assign status.mode     = mode_r;
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_heading     = out_heading_r;
  assign out_bias        = out_bias_r;
  assign out_drift       = out_drift_r;
  assign out_bias_ready  = out_bias_ready_r;
  assign out_drift_ready = out_drift_ready_r;

endmodule

// ===== design/gyro_heading_integrator_core.sv =====
// Channel  Direction  Beat contents
// in_ch    sink       mode, raw_rate, elapsed_us
// out_ch   source     heading_out, bias_out, drift_out, bias_ready, drift_ready
// cfg      write      cfg_we, cfg_idx, cfg_wdata (0 rate_gain, 1 drift_period_us)
//
// One sample is handled at a time: a new sample is accepted only once the result beat of
// the last one is loaded. The integrating path is set by four passes through the single
// 32x32 multiplier plus the modulo, heading and correction steps; a drift sample adds a window
// step, a calibration sample takes an accumulation step only and an ignored mode goes straight to its result beat.
// Reset is synchronous and active low and needs no clearing pass.
// A stalled result beat holds the block in its output state until taken.
module gyro_heading_integrator_core #(
  parameter int CAL_COUNT = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  gyhi_in_if.sink                     in_ch,
  gyhi_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic                        cfg_idx,
  input  logic [gyhi_pkg::GAIN_W-1:0] cfg_wdata
);

  gyhi_pkg::cmd_t    cmd;
  gyhi_pkg::status_t status;
  logic              in_ready;

  assign in_ch.ready = in_ready;

  gyhi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  gyhi_dpath #(
    .CAL_COUNT (CAL_COUNT)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata),
    .in_mode         (in_ch.mode),
    .in_raw_rate     (in_ch.raw_rate),
    .in_elapsed_us   (in_ch.elapsed_us),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_heading     (out_ch.heading_out),
    .out_bias        (out_ch.bias_out),
    .out_drift       (out_ch.drift_out),
    .out_bias_ready  (out_ch.bias_ready),
    .out_drift_ready (out_ch.drift_ready)
  );

endmodule

// ===== tb/sv/tb.sv =====
module tb;

  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 11;
  localparam int CAL_LEN        = 256;
  localparam int SETTLE_CYCLES  = 16;
  localparam int PRESSURE_HOLD  = 400;
  localparam int TIMEOUT_CYCLES = 600000;
  localparam int MAX_PRINTS     = 40;
  localparam int NUM_ROWS       = 20;

  // Mode 3 has no name in the package; the block reports its state unchanged.
  localparam logic [gyhi_pkg::MODE_W-1:0] MODE_IGNORED = 2'd3;

  localparam longint unsigned TURN      = 64'(gyhi_pkg::FULL_CIRCLE);
  localparam longint unsigned TIMER_TOP = 64'hFFFF_FFFF;
  localparam longint unsigned EL_TOP    = 64'hFF_FFFF;

  typedef enum {CAL_UNIFORM, CAL_NEAR, CAL_MIN, CAL_MAX} cal_style_t;

  // One result beat as the output channel carries it.
  typedef struct packed {
    logic [gyhi_pkg::HEAD_W-1:0]  heading;
    logic [gyhi_pkg::BIAS_W-1:0]  bias;
    logic [gyhi_pkg::DRIFT_W-1:0] drift;
    logic                         bias_rdy;
    logic                         drift_rdy;
  } heading_result_t;

  // One row of the directed stimulus; typed rows carry their own expectation.
  typedef struct packed {
    logic [gyhi_pkg::MODE_W-1:0] mode;
    logic [gyhi_pkg::RAW_W-1:0]  raw;
    logic [gyhi_pkg::EL_W-1:0]   el;
    logic                        typed;
    heading_result_t             want;
  } stim_row_t;

  localparam heading_result_t ZERO_BEAT = '0;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic                          cfg_idx;
  logic [gyhi_pkg::GAIN_W-1:0]   cfg_wdata;

  gyhi_in_if  in_if ();
  gyhi_out_if out_if ();

  gyro_heading_integrator_core #(
    .CAL_COUNT(CAL_LEN)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // Directed rows run under the reset register values.
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{MODE_IGNORED,         16'h0007, 24'd5,       1'b1, ZERO_BEAT},
    '{gyhi_pkg::MODE_INT,   16'h7FFF, 24'd0,       1'b1, ZERO_BEAT},
    '{gyhi_pkg::MODE_INT,   16'h8000, 24'd0,       1'b1, ZERO_BEAT},
    '{gyhi_pkg::MODE_INT,   16'h7FFF, 24'hFFFFFF,  1'b0, ZERO_BEAT},
    '{gyhi_pkg::MODE_INT,   16'h8000, 24'hFFFFFF,  1'b0, ZERO_BEAT},
    '{gyhi_pkg::MODE_INT,   16'h0001, 24'd1000,    1'b0, ZERO_BEAT},
    '{gyhi_pkg::MODE_DRIFT, 16'd100,  24'd1000,    1'b0, ZERO_BEAT},
    '{gyhi_pkg::MODE_DRIFT, 16'd100,  24'd600000,  1'b0, ZERO_BEAT},
    '{gyhi_pkg::MODE_DRIFT, 16'd100,  24'd600000,  1'b0, ZERO_BEAT},
    '{gyhi_pkg::MODE_INT,   16'h0000, 24'd2000000, 1'b0, ZERO_BEAT},
    '{gyhi_pkg::MODE_DRIFT, 16'hFF38, 24'd10,      1'b0, ZERO_BEAT},
    '{gyhi_pkg::MODE_CAL,   16'h8000, 24'd0,       1'b0, ZERO_BEAT},
    '{gyhi_pkg::MODE_DRIFT, 16'h8000, 24'hFFFFFF,  1'b0, ZERO_BEAT},
    '{gyhi_pkg::MODE_DRIFT, 16'h8000, 24'hFFFFFF,  1'b0, ZERO_BEAT},
    '{MODE_IGNORED,         16'hFFFF, 24'hFFFFFF,  1'b0, ZERO_BEAT},
    '{gyhi_pkg::MODE_INT,   16'h0000, 24'd0,       1'b0, ZERO_BEAT},
    '{gyhi_pkg::MODE_DRIFT, 16'h7FFF, 24'd500,     1'b0, ZERO_BEAT},
    '{MODE_IGNORED,         16'h0000, 24'd0,       1'b0, ZERO_BEAT},
    '{gyhi_pkg::MODE_DRIFT, 16'h7FFF, 24'd999500,  1'b0, ZERO_BEAT},
    '{gyhi_pkg::MODE_DRIFT, 16'h0000, 24'd500,     1'b0, ZERO_BEAT}
  };

  // Predicted register and state copy.
  longint unsigned p_gain, p_period;
  longint unsigned p_heading, p_corr_timer, p_win_timer, p_win_start;
  longint          p_bias, p_drift, p_bias_sum;
  int unsigned     p_bias_cnt;
  bit              p_bias_rdy, p_drift_rdy, p_win_open;

  heading_result_t pending_headings [$];

  int tx_idle_pct;
  int rx_stall_pct;
  int hold_off_left;
  int mismatch_count;
  int samples_sent;
  int useful_sent;
  int beats_checked;
  int averages_done;
  int windows_closed;
  int corrections_fired;

  // Free-running clock.
  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic longint unsigned timer_add(longint unsigned a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > TIMER_TOP) ? TIMER_TOP : s;
  endfunction

  // Move the heading by a magnitude in either direction around the circle.
  function automatic void rotate_heading(bit neg, longint unsigned mag);
    longint unsigned r, h;
    r = mag % TURN;
    h = p_heading % TURN;
    p_heading = neg ? (h + TURN - r) % TURN : (h + r) % TURN;
  endfunction

  // Rate integration followed by the periodic drift correction.
  function automatic void integrate_rate(longint raw, longint unsigned el);
    longint          d, dmag;
    bit              neg, dneg;
    longint unsigned mag;
    logic [95:0]     prod;
    d = raw * 256 - p_bias;
    neg = d < 0;
    mag = neg ? longint'(-d) : longint'(d);
    prod = 96'(mag * el) * 96'(p_gain) + (96'd1 << 39);
    rotate_heading(neg, 64'(prod >> 40));
    p_corr_timer = timer_add(p_corr_timer, el);
    if (p_corr_timer > p_period) begin
      dneg = p_drift < 0;
      dmag = dneg ? -p_drift : p_drift;
      rotate_heading(!dneg, longint'(dmag));
      p_corr_timer = 0;
      corrections_fired++;
    end
  endfunction

  // Advance the state copy by one sample and form the beat it causes.
  function automatic heading_result_t predict_heading_beat(
      logic [gyhi_pkg::MODE_W-1:0] mode,
      logic [gyhi_pkg::RAW_W-1:0] raw_bits,
      logic [gyhi_pkg::EL_W-1:0] el_bits);
    longint          raw, dv;
    longint unsigned el, mag, q, diff;
    bit              neg;
    heading_result_t beat;
    raw = longint'($signed(raw_bits));
    el = 64'(el_bits);
    case (mode)
      gyhi_pkg::MODE_INT: begin
        p_win_open = 1'b0;
        integrate_rate(raw, el);
      end
      gyhi_pkg::MODE_CAL: begin
        p_win_open = 1'b0;
        p_bias_sum += raw;
        p_bias_cnt++;
        if (p_bias_cnt >= CAL_LEN) begin
          neg = p_bias_sum < 0;
          mag = neg ? longint'(-p_bias_sum) : longint'(p_bias_sum);
          q = (mag * 256 + CAL_LEN / 2) / CAL_LEN;
          p_bias = neg ? -longint'(q) : longint'(q);
          p_bias_sum = 0;
          p_bias_cnt = 0;
          p_bias_rdy = 1'b1;
          averages_done++;
        end
      end
      gyhi_pkg::MODE_DRIFT: begin
        integrate_rate(raw, el);
        if (!p_win_open) begin
          p_win_start = p_heading;
          p_win_timer = 0;
          p_win_open = 1'b1;
        end else begin
          p_win_timer = timer_add(p_win_timer, el);
          if (p_win_timer >= p_period) begin
            // Shortest signed difference, so a pass through north measures right.
            diff = (p_heading + TURN - p_win_start % TURN) % TURN;
            dv = longint'(diff);
            if (diff >= TURN / 2) dv -= longint'(TURN);
            p_drift = dv;
            p_drift_rdy = 1'b1;
            p_win_open = 1'b0;
            windows_closed++;
          end
        end
      end
      default: begin
        // Ignored mode leaves everything as it is, an open window included.
      end
    endcase
    beat.heading   = gyhi_pkg::HEAD_W'(p_heading);
    beat.bias      = gyhi_pkg::BIAS_W'(p_bias);
    beat.drift     = gyhi_pkg::DRIFT_W'(p_drift);
    beat.bias_rdy  = p_bias_rdy;
    beat.drift_rdy = p_drift_rdy;
    return beat;
  endfunction

  task automatic flag_mismatch(string what);
    if (mismatch_count < MAX_PRINTS) $display("[%0t] MISMATCH %s", $time, what);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // Compare one taken result beat against the oldest prediction.
  task automatic check_heading_beat();
    heading_result_t want;
    if (pending_headings.size() == 0) begin
      flag_mismatch("result beat arrived with nothing predicted");
    end else begin
      want = pending_headings.pop_front();
      check_field("heading_out", 32'(out_if.heading_out), 32'(want.heading));
      check_field("bias_out", 32'($unsigned(out_if.bias_out)), 32'(want.bias));
      check_field("drift_out", 32'($unsigned(out_if.drift_out)), 32'(want.drift));
      check_field("bias_ready", 32'(out_if.bias_ready), 32'(want.bias_rdy));
      check_field("drift_ready", 32'(out_if.drift_ready), 32'(want.drift_rdy));
      beats_checked++;
    end
  endtask

  // Result side: take beats, stall at random, or hold off for a long stretch.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) check_heading_beat();
    if (hold_off_left > 0) begin
      out_if.ready <= 1'b0;
      hold_off_left--;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Offer one sample beat, with random idle cycles ahead of it.
  task automatic send_sample(logic [gyhi_pkg::MODE_W-1:0] mode,
                             logic [gyhi_pkg::RAW_W-1:0] raw,
                             logic [gyhi_pkg::EL_W-1:0] el, logic typed,
                             heading_result_t want);
    heading_result_t beat;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.mode       <= mode;
    in_if.raw_rate   <= raw;
    in_if.elapsed_us <= el;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    beat = predict_heading_beat(mode, raw, el);
    pending_headings.push_back(typed ? want : beat);
    samples_sent++;
    if (mode != MODE_IGNORED) useful_sent++;
  endtask

  // Wait until every predicted beat has come out and the block has settled.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_headings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_registers(logic [31:0] gain, logic [31:0] period);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_idx   <= gyhi_pkg::CFG_RATE_GAIN;
    cfg_wdata <= gain;
    @(posedge clk);
    cfg_idx   <= gyhi_pkg::CFG_DRIFT_PERIOD;
    cfg_wdata <= period;
    @(posedge clk);
    cfg_we    <= 1'b0;
    p_gain   = 64'(gain);
    p_period = 64'(period);
  endtask

  function automatic logic [gyhi_pkg::EL_W-1:0] rand_elapsed();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return gyhi_pkg::EL_W'($urandom);
      default: return gyhi_pkg::EL_W'($urandom_range(0, 20000));
    endcase
  endfunction

  // Mostly full-range rates, some close to the bias so the difference is small.
  function automatic logic [gyhi_pkg::RAW_W-1:0] rand_rate();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return gyhi_pkg::RAW_W'($urandom);
    if (pick < 8) return gyhi_pkg::RAW_W'(p_bias >>> 8)
                         + gyhi_pkg::RAW_W'($urandom_range(0, 200)) - 16'd100;
    if (pick == 8) return 16'h8000;
    return 16'h7FFF;
  endfunction

  task automatic calibration_burst(int len, cal_style_t style);
    logic [gyhi_pkg::RAW_W-1:0] center, raw;
    center = gyhi_pkg::RAW_W'($urandom);
    repeat (len) begin
      case (style)
        CAL_UNIFORM: raw = gyhi_pkg::RAW_W'($urandom);
        CAL_NEAR:    raw = center + gyhi_pkg::RAW_W'($urandom_range(0, 63)) - 16'd32;
        CAL_MIN:     raw = 16'h8000;
        default:     raw = 16'h7FFF;
      endcase
      send_sample(gyhi_pkg::MODE_CAL, raw, gyhi_pkg::EL_W'($urandom), 1'b0, ZERO_BEAT);
    end
  endtask

  // A drift window paced to close in a few samples, now and then broken off.
  task automatic drift_window();
    longint unsigned step, el;
    int              k;
    k = $urandom_range(2, 10);
    step = p_period / k;
    if (step > EL_TOP) step = EL_TOP;
    send_sample(gyhi_pkg::MODE_DRIFT, rand_rate(), gyhi_pkg::EL_W'($urandom_range(0, 5000)),
                1'b0, ZERO_BEAT);
    for (int i = 0; i < 40 && p_win_open; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_sample($urandom_range(0, 1) ? gyhi_pkg::MODE_INT : gyhi_pkg::MODE_CAL,
                    rand_rate(), rand_elapsed(), 1'b0, ZERO_BEAT);
      end else begin
        el = step / 2 + $urandom_range(0, 32'(step + 1));
        if (el > EL_TOP) el = EL_TOP;
        send_sample(gyhi_pkg::MODE_DRIFT, rand_rate(), gyhi_pkg::EL_W'(el), 1'b0, ZERO_BEAT);
      end
    end
  endtask

  // Random runs of integration, drift windows, calibration and noise.
  task automatic random_traffic(int target);
    int start_count, pick, len;
    start_count = useful_sent;
    while (useful_sent - start_count < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        len = $urandom_range(5, 30);
        repeat (len) send_sample(gyhi_pkg::MODE_INT, rand_rate(), rand_elapsed(), 1'b0,
                                 ZERO_BEAT);
      end else if (pick < 60) begin
        drift_window();
      end else if (pick < 72) begin
        if ($urandom_range(0, 4) == 0) len = CAL_LEN - p_bias_cnt;
        else len = $urandom_range(1, 30);
        calibration_burst(len, cal_style_t'($urandom_range(0, 3)));
      end else if (pick < 82) begin
        len = $urandom_range(1, 3);
        repeat (len) send_sample(MODE_IGNORED, gyhi_pkg::RAW_W'($urandom),
                                 gyhi_pkg::EL_W'($urandom), 1'b0, ZERO_BEAT);
      end else begin
        len = $urandom_range(3, 15);
        repeat (len) send_sample(gyhi_pkg::MODE_W'($urandom_range(0, 3)), rand_rate(),
                                 rand_elapsed(), 1'b0, ZERO_BEAT);
      end
    end
  endtask

  initial begin
    // Known values on every input from time zero.
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = gyhi_pkg::CFG_RATE_GAIN;
    cfg_wdata        = '0;
    in_if.valid      = 1'b0;
    in_if.mode       = gyhi_pkg::MODE_INT;
    in_if.raw_rate   = '0;
    in_if.elapsed_us = '0;
    out_if.ready     = 1'b0;
    tx_idle_pct      = 0;
    rx_stall_pct     = 0;
    hold_off_left    = 0;

    // State copy after reset.
    p_gain       = 64'(gyhi_pkg::RATE_GAIN_RST);
    p_period     = 64'(gyhi_pkg::DRIFT_PERIOD_RST);
    p_heading    = 0;
    p_corr_timer = 0;
    p_win_timer  = 0;
    p_win_start  = 0;
    p_bias       = 0;
    p_drift      = 0;
    p_bias_sum   = 0;
    p_bias_cnt   = 0;
    p_bias_rdy   = 1'b0;
    p_drift_rdy  = 1'b0;
    p_win_open   = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows under the reset register values, no idling.
    foreach (directed_rows[i]) begin
      send_sample(directed_rows[i].mode, directed_rows[i].raw, directed_rows[i].el,
                  directed_rows[i].typed, directed_rows[i].want);
    end

    // Reset values written back; the bias average lands on its lowest value.
    load_registers(gyhi_pkg::RATE_GAIN_RST, gyhi_pkg::DRIFT_PERIOD_RST);
    calibration_burst(CAL_LEN - p_bias_cnt, CAL_MIN);
    random_traffic(120);

    // Largest gain and period, sender mostly idle.
    load_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    tx_idle_pct = 85;
    random_traffic(120);

    // No gain and a period of one, receiver mostly stalled.
    load_registers(32'd0, 32'd1);
    tx_idle_pct  = 0;
    rx_stall_pct = 85;
    random_traffic(120);

    // Random settings, both sides idling; the bias average reaches its top.
    load_registers($urandom, $urandom_range(1000, 3000000));
    tx_idle_pct  = 38;
    rx_stall_pct = 38;
    if (p_bias_cnt != 0) calibration_burst(CAL_LEN - p_bias_cnt, CAL_UNIFORM);
    calibration_burst(CAL_LEN, CAL_MAX);
    random_traffic(120);

    // Period zero; the receiver holds off while samples keep coming.
    load_registers($urandom, 32'd0);
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    hold_off_left = PRESSURE_HOLD;
    repeat (30) send_sample(gyhi_pkg::MODE_INT, rand_rate(), rand_elapsed(), 1'b0, ZERO_BEAT);
    random_traffic(90);

    drain_results();
    $display("Sent %0d gyro samples (%0d in the ignored mode) across five register settings.",
             samples_sent, samples_sent - useful_sent);
    $display("Checked %0d beats: %0d bias averages, %0d drift windows, %0d corrections.",
             beats_checked, averages_done, windows_closed, corrections_fired);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/gyhi_pkg.sv
design/gyhi_if.sv
design/gyhi_mult.sv
design/gyhi_ctrl.sv
design/gyhi_dpath.sv
design/gyro_heading_integrator_core.sv
tb/sv/tb.sv
